### rtl/core/gds_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date subtractor.
// Used by gds_ctrl, gds_dp and gregorian_date_subtract; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gds_pkg;

    // default field widths
    localparam int AMOUNT_BITS_DEF = 12;
    localparam int YEAR_BITS_DEF   = 14;

    // calendar constants
    localparam int YEAR_MAX   = 9999;
    localparam int YEAR_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int MONTHS     = 12;
    localparam int LONG_MONTH = 31;
    localparam int MOD_W      = 9;

    // year / 400 by reciprocal: floor(y * MOD_RECIP / 2^MOD_RECIP_SHIFT), exact for y < 2^16
    localparam int YEAR_W_MAX      = 16;
    localparam int MOD_RECIP       = 83887;
    localparam int MOD_RECIP_SHIFT = 25;
    localparam int QUO_W           = 8;

    // request kinds
    localparam logic [1:0] REQ_DAY   = 2'd0;
    localparam logic [1:0] REQ_MONTH = 2'd1;
    localparam logic [1:0] REQ_YEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       mod_step;
        logic       step_day;
        logic       step_month;
        logic       ysub;
        logic       yclamp;
        logic       set_st;
        logic [1:0] st_val;
        logic       out_load;
    } gds_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       mod_last;
        logic       date_ok;
        logic [1:0] req;
        logic       cnt_zero;
        logic       year_zero;
        logic       amt_ge_year;
    } gds_stat_t;

    // leap year from the year modulo 400
    function automatic logic is_leap(input logic [MOD_W-1:0] r);
        logic hit;
        hit = (r == MOD_W'(CENTURY)) || (r == MOD_W'(2 * CENTURY)) ||
              (r == MOD_W'(3 * CENTURY));
        return (r[1:0] == 2'b00) && !hit;
    endfunction

    // length of a month; codes outside 1..12 read as 31
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'(LONG_MONTH);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/core/gregorian_date_subtract.sv
// Gregorian date subtractor, top level: stream ports, word packing, ctrl + datapath.
// Day/month requests run a one-step-per-cycle loop that ends early if the year runs out;
// year requests subtract the amount from the year. The leap rule uses a mod-400 unit
// that forms the quotient by reciprocal, then the remainder. One word in flight; the
// next is taken once the sequencer is back in idle, entered as the result loads the output
// register (waits on m_tready). aresetn (sync, low) clears the sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_subtract #(
    parameter int AMOUNT_BITS = gds_pkg::AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = gds_pkg::YEAR_BITS_DEF
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        s_tvalid,
    output logic                                       s_tready,
    // amount, start_day, start_month, start_year (LSB up), zero pad
    input  wire  [((AMOUNT_BITS+YEAR_BITS+9+7)/8)*8-1:0] s_tdata,
    // req_type
    input  wire  [1:0]                                 s_tuser,
    output logic                                       m_tvalid,
    input  wire                                        m_tready,
    // out_day, out_month, out_year (LSB up), zero pad
    output logic [((YEAR_BITS+9+7)/8)*8-1:0]           m_tdata,
    // status
    output logic [1:0]                                 m_tuser
);
    import gds_pkg::*;

    localparam int OUT_W = ((YEAR_BITS + 9 + 7) / 8) * 8;
    localparam int D_LO  = AMOUNT_BITS;
    localparam int M_LO  = AMOUNT_BITS + 5;
    localparam int Y_LO  = AMOUNT_BITS + 9;

    gds_cmd_t             cmd;
    gds_stat_t            stat;
    logic [4:0]           out_day;
    logic [3:0]           out_month;
    logic [YEAR_BITS-1:0] out_year;

    gds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gds_dp #(
        .AMOUNT_BITS (AMOUNT_BITS),
        .YEAR_BITS   (YEAR_BITS)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_tuser),
        .in_amount  (s_tdata[AMOUNT_BITS-1:0]),
        .in_day     (s_tdata[D_LO+4:D_LO]),
        .in_month   (s_tdata[M_LO+3:M_LO]),
        .in_year    (s_tdata[Y_LO+YEAR_BITS-1:Y_LO]),
        .out_day    (out_day),
        .out_month  (out_month),
        .out_year   (out_year),
        .out_status (m_tuser)
    );

    // result word packing
    assign m_tdata = OUT_W'({out_year, out_month, out_day});

endmodule

`default_nettype wire

### rtl/core/gds_dp.sv
// Datapath of the date subtractor: date registers, step counter, mod-400 unit,
// output registers. Driven by gds_ctrl through gds_pkg command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module gds_dp #(
    parameter int AMOUNT_BITS = gds_pkg::AMOUNT_BITS_DEF,
    parameter int YEAR_BITS   = gds_pkg::YEAR_BITS_DEF
) (
    input  wire                      aclk,
    input  wire gds_pkg::gds_cmd_t   cmd,
    output gds_pkg::gds_stat_t       stat,
    input  wire  [1:0]               in_req,
    input  wire  [AMOUNT_BITS-1:0]   in_amount,
    input  wire  [4:0]               in_day,
    input  wire  [3:0]               in_month,
    input  wire  [YEAR_BITS-1:0]     in_year,
    output logic [4:0]               out_day,
    output logic [3:0]               out_month,
    output logic [YEAR_BITS-1:0]     out_year,
    output logic [1:0]               out_status
);
    import gds_pkg::*;

    localparam int CW     = (AMOUNT_BITS > YEAR_BITS) ? AMOUNT_BITS : YEAR_BITS;
    localparam int PROD_W = MOD_RECIP_SHIFT + QUO_W;
    localparam int MC_W   = YEAR_W_MAX + 1;

    logic [1:0]             req_reg, req_next;
    logic [4:0]             day_reg, day_next, day0_reg, day0_next;
    logic [3:0]             month_reg, month_next, month0_reg, month0_next;
    logic [YEAR_BITS-1:0]   year_reg, year_next, year0_reg, year0_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [AMOUNT_BITS-1:0] cnt_reg, cnt_next, amt_reg, amt_next;
    logic [MOD_W-1:0]       mod_reg, mod_next, mod_dec;
    logic                   phase_reg, phase_next;
    logic [1:0]             st_reg, st_next;
    logic [4:0]             oday_reg, oday_next;
    logic [3:0]             omonth_reg, omonth_next;
    logic [YEAR_BITS-1:0]   oyear_reg, oyear_next;
    logic [1:0]             ost_reg, ost_next;

    logic                   leap;
    logic [4:0]             len_cur, len_prev;
    logic [3:0]             month_prev;
    logic [PROD_W-1:0]      quo_prod;
    logic [MC_W-1:0]        mod_calc;
    logic [YEAR_BITS-1:0]   year_sub;

    // calendar helpers on the current date
    always_comb begin
        leap       = is_leap(mod_reg);
        month_prev = month_reg - 4'd1;
        len_cur    = month_days(month_reg, leap);
        len_prev   = month_days(month_prev, leap);
        mod_dec    = (mod_reg == '0) ? MOD_W'(YEAR_CYCLE - 1) : mod_reg - MOD_W'(1);
        quo_prod   = PROD_W'(year_reg) * PROD_W'(MOD_RECIP);
        mod_calc   = MC_W'(year_reg) - MC_W'(quo_reg) * MC_W'(YEAR_CYCLE);
        year_sub   = year_reg - YEAR_BITS'(amt_reg);
    end

    // status back to the controller
    always_comb begin
        stat.mod_last    = phase_reg;
        stat.date_ok     = (req_reg != 2'd3) && (month_reg >= 4'd1) &&
                           (month_reg <= 4'(MONTHS)) && (year_reg != '0) &&
                           (32'(year_reg) <= YEAR_MAX) && (day_reg != 5'd0) &&
                           (day_reg <= len_cur);
        stat.req         = req_reg;
        stat.cnt_zero    = (cnt_reg == '0);
        stat.year_zero   = (year_reg == '0);
        stat.amt_ge_year = (CW'(amt_reg) >= CW'(year_reg));
    end

    // next-state logic of the date registers
    always_comb begin
        req_next    = req_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        day0_next   = day0_reg;
        month0_next = month0_reg;
        year0_next  = year0_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        amt_next    = amt_reg;
        mod_next    = mod_reg;
        phase_next  = phase_reg;
        st_next     = st_reg;
        oday_next   = oday_reg;
        omonth_next = omonth_reg;
        oyear_next  = oyear_reg;
        ost_next    = ost_reg;

        if (cmd.load) begin
            req_next    = in_req;
            day_next    = in_day;
            month_next  = in_month;
            year_next   = in_year;
            day0_next   = in_day;
            month0_next = in_month;
            year0_next  = in_year;
            cnt_next    = in_amount;
            amt_next    = in_amount;
            mod_next    = '0;
            phase_next  = 1'b0;
        end

        // year mod 400: quotient by reciprocal first, then year - 400 * quotient
        if (cmd.mod_step) begin
            if (!phase_reg) begin
                quo_next = quo_prod[MOD_RECIP_SHIFT +: QUO_W];
            end else begin
                mod_next = mod_calc[MOD_W-1:0];
            end
            phase_next = !phase_reg;
        end

        // year request: lower the year and restart the mod unit on it
        if (cmd.ysub) begin
            year_next  = year_sub;
            mod_next   = '0;
            phase_next = 1'b0;
        end

        if (cmd.yclamp) begin
            if (day_reg > len_cur) begin
                day_next = len_cur;
            end
        end

        // one day back
        if (cmd.step_day) begin
            cnt_next = cnt_reg - AMOUNT_BITS'(1);
            if (day_reg > 5'd1) begin
                day_next = day_reg - 5'd1;
            end else if (month_reg == 4'd1) begin
                year_next  = year_reg - YEAR_BITS'(1);
                mod_next   = mod_dec;
                month_next = 4'(MONTHS);
                day_next   = 5'(LONG_MONTH);
            end else begin
                month_next = month_prev;
                day_next   = len_prev;
            end
        end

        // one month back, day clamped to the new month
        if (cmd.step_month) begin
            cnt_next = cnt_reg - AMOUNT_BITS'(1);
            if (month_reg == 4'd1) begin
                year_next  = year_reg - YEAR_BITS'(1);
                mod_next   = mod_dec;
                month_next = 4'(MONTHS);
            end else begin
                month_next = month_prev;
                if (day_reg > len_prev) begin
                    day_next = len_prev;
                end
            end
        end

        if (cmd.set_st) begin
            st_next = cmd.st_val;
        end

        // any failure returns the start date
        if (cmd.out_load) begin
            ost_next = st_reg;
            if (st_reg != ST_OK) begin
                oday_next   = day0_reg;
                omonth_next = month0_reg;
                oyear_next  = year0_reg;
            end else begin
                oday_next   = day_reg;
                omonth_next = month_reg;
                oyear_next  = year_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        day0_reg   <= day0_next;
        month0_reg <= month0_next;
        year0_reg  <= year0_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        amt_reg    <= amt_next;
        mod_reg    <= mod_next;
        phase_reg  <= phase_next;
        st_reg     <= st_next;
        oday_reg   <= oday_next;
        omonth_reg <= omonth_next;
        oyear_reg  <= oyear_next;
        ost_reg    <= ost_next;
    end

    assign out_day    = oday_reg;
    assign out_month  = omonth_reg;
    assign out_year   = oyear_reg;
    assign out_status = ost_reg;

endmodule

`default_nettype wire

### rtl/core/gds_ctrl.sv
// Controller of the date subtractor: one-hot sequencer plus result word valid flag.
// Talks to gds_dp only through gds_pkg::gds_cmd_t and gds_pkg::gds_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module gds_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    input  wire gds_pkg::gds_stat_t  stat,
    output gds_pkg::gds_cmd_t        cmd
);
    import gds_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MOD    = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_DSTEP  = 8'b0000_1000,
        S_MSTEP  = 8'b0001_0000,
        S_YMOD   = 8'b0010_0000,
        S_YCLAMP = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    // sequencer
    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE);

        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (!stat.date_ok) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = ST_BAD;
                    state_next = S_FINISH;
                end else if (stat.req == REQ_DAY) begin
                    state_next = S_DSTEP;
                end else if (stat.req == REQ_MONTH) begin
                    state_next = S_MSTEP;
                end else if (stat.amt_ge_year) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = ST_UNDER;
                    state_next = S_FINISH;
                end else begin
                    cmd.ysub   = 1'b1;
                    state_next = S_YMOD;
                end
            end
            S_DSTEP, S_MSTEP: begin
                priority if (stat.year_zero) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = ST_UNDER;
                    state_next = S_FINISH;
                end else if (stat.cnt_zero) begin
                    cmd.set_st = 1'b1;
                    cmd.st_val = ST_OK;
                    state_next = S_FINISH;
                end else begin
                    cmd.step_day   = (state_reg == S_DSTEP);
                    cmd.step_month = (state_reg == S_MSTEP);
                end
            end
            S_YMOD: begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last) begin
                    state_next = S_YCLAMP;
                end
            end
            S_YCLAMP: begin
                cmd.yclamp = 1'b1;
                cmd.set_st = 1'b1;
                cmd.st_val = ST_OK;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // wait until the output register is free
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire
